>>> sv/itv_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itv_pkg
// Shared types and constants for the interval timer bank with windowed
// average.
// ---------------------------------------------------------------------------
package itv_pkg;

  // Payload widths
  localparam int TS_W     = 48;
  localparam int VAL_W    = 49;
  localparam int KIND_W   = 2;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 2;

  // Divider: quotient bits resolved per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = TS_W / DIV_BITS;

  // Item kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_LAST  = 2'd2,
    KIND_AVG   = 2'd3
  } kind_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_LOOK,
    S_AVG_RD,
    S_AVG_GO,
    S_AVG_DIV,
    S_FIN_GO,
    S_FIN_DIV,
    S_RESP
  } seq_state_t;

endpackage
`default_nettype wire

>>> sv/itv_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itv_in_if
// Request channel: one timer transaction per valid/ready handshake.
// ---------------------------------------------------------------------------
interface itv_in_if;
  logic                      valid;
  logic                      ready;
  logic [itv_pkg::KIND_W-1:0] kind;
  logic [itv_pkg::ID_W-1:0]   timer_id;
  logic [itv_pkg::TS_W-1:0]   timestamp;

  modport source (output valid, output kind, output timer_id, output timestamp,
                  input ready);
  modport sink   (input valid, input kind, input timer_id, input timestamp,
                  output ready);
endinterface
`default_nettype wire

>>> sv/itv_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itv_out_if
// Response channel: one result transaction per valid/ready handshake.
// ---------------------------------------------------------------------------
interface itv_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [itv_pkg::VAL_W-1:0]  value;
  logic [itv_pkg::STATUS_W-1:0]      status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface
`default_nettype wire

>>> sv/itv_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itv_div
// Iterative unsigned divider: 48-bit dividend by a narrow divisor, restoring
// algorithm resolving DIV_BITS quotient bits per cycle.
// ---------------------------------------------------------------------------
module itv_div #(
  parameter int DVS_W = 7
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire [itv_pkg::TS_W-1:0]  dividend,
  input  wire [DVS_W-1:0]          divisor,
  output logic                     done,
  output logic [itv_pkg::TS_W-1:0] quotient,
  output logic [DVS_W-1:0]         remainder
);
  import itv_pkg::*;

  localparam int SC_W = $clog2(DIV_STEPS + 1);

  logic              busy;
  logic [SC_W-1:0]   step;
  logic [TS_W-1:0]   sh;
  logic [DVS_W-1:0]  rm;
  logic [DVS_W-1:0]  dvs;

  logic [TS_W-1:0]   sh_next;
  logic [DVS_W-1:0]  rm_next;
  logic [DVS_W:0]    trial;

  // One cycle's worth of restoring steps
  always_comb begin
    sh_next = sh;
    rm_next = rm;
    trial   = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial   = {rm_next, sh_next[TS_W-1]};
      sh_next = {sh_next[TS_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial      = trial - {1'b0, dvs};
        sh_next[0] = 1'b1;
      end
      rm_next = trial[DVS_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == SC_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rm  <= '0;
      dvs <= divisor;
    end else if (busy) begin
      sh <= sh_next;
      rm <= rm_next;
    end
  end

  assign quotient  = sh;
  assign remainder = rm;

endmodule
`default_nettype wire

>>> sv/interval_timer_moving_average.sv
`default_nettype none
// Start, end and read-last: the sequencer steps through fetch, lookup and response,
// loading the output register on return to idle, where the next transaction is taken;
// the response state waits while the output holds an untaken result. Average over n
// held samples: each sample takes a ring read, a divider launch and a divider run (8
// quotient bits per cycle, then done), and the summed remainders take a final division.
// Reset clears the timer-known flags, the sequencer and the output valid; no clearing pass.
// ---------------------------------------------------------------------------
// interval_timer_moving_average
// Bank of interval timers, each with a ring of recent elapsed samples and a
// windowed average computed sample by sample through one shared divider.
// ---------------------------------------------------------------------------
module interval_timer_moving_average #(
  parameter int NUM_TIMERS    = 16,
  parameter int HISTORY_DEPTH = 100
) (
  input  wire  clk,
  input  wire  rst,
  itv_in_if.sink    req,
  itv_out_if.source rsp
);
  import itv_pkg::*;

  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int RW = 2 * CW + 1;
  localparam int RING_DEPTH = NUM_TIMERS << PW;

  seq_state_t state, state_next;

  // Captured transaction
  logic [KIND_W-1:0] kind_r;
  logic [TW-1:0]     t_r;
  logic              id_ok_r;
  logic [TS_W-1:0]   ts_r;

  // Timer state
  logic [NUM_TIMERS-1:0] known_q;
  logic [TS_W-1:0]  start_mem [NUM_TIMERS];
  logic [VAL_W-1:0] last_mem  [NUM_TIMERS];
  logic [PW-1:0]    pos_mem   [NUM_TIMERS];
  logic [CW-1:0]    cnt_mem   [NUM_TIMERS];
  logic [VAL_W-1:0] ring_mem  [RING_DEPTH];
  logic [TS_W-1:0]  start_rd;
  logic [VAL_W-1:0] last_rd;
  logic [PW-1:0]    pos_rd;
  logic [CW-1:0]    cnt_rd;
  logic [VAL_W-1:0] ring_rd;

  // Average accumulators
  logic [PW-1:0]    idx;
  logic [CW-1:0]    cnt_r;
  logic [VAL_W-1:0] qacc;
  logic [RW-1:0]    racc;
  logic             neg_r;

  // Results
  logic [VAL_W-1:0]    res_value;
  logic [STATUS_W-1:0] res_status;
  logic                out_valid;
  logic [VAL_W-1:0]    out_value;
  logic [STATUS_W-1:0] out_status;

  // Sequencer outputs
  logic                take;
  logic                wr_start, wr_init, wr_end, set_known;
  logic                acc_clr, acc_add, div_start, res_load, out_load;
  logic [VAL_W-1:0]    res_v;
  logic [STATUS_W-1:0] res_s;

  // Datapath helpers
  logic [VAL_W-1:0] elapsed;
  logic [PW-1:0]    wp, wp_next;
  logic [CW-1:0]    cnt_next;
  logic [VAL_W-1:0] ring_mag;
  logic [RW-1:0]    racc_mag;
  logic [TS_W-1:0]  div_dvd;
  logic             div_done;
  logic [TS_W-1:0]  div_quo;
  logic [CW-1:0]    div_rem;
  logic [VAL_W-1:0] q_ext;
  logic [RW-1:0]    r_ext;
  logic             last_sample;

  assign elapsed  = {1'b0, ts_r} - {1'b0, start_rd};
  assign wp       = (32'(pos_rd) >= HISTORY_DEPTH) ? '0 : pos_rd;
  assign wp_next  = (wp == PW'(HISTORY_DEPTH - 1)) ? '0 : wp + 1'b1;
  assign cnt_next = (cnt_rd < CW'(HISTORY_DEPTH)) ? cnt_rd + 1'b1 : cnt_rd;
  assign ring_mag = ring_rd[VAL_W-1] ? -ring_rd : ring_rd;
  assign racc_mag = racc[RW-1] ? -racc : racc;
  assign div_dvd  = (state == S_FIN_GO) ? {{(TS_W-RW){1'b0}}, racc_mag}
                                        : ring_mag[TS_W-1:0];
  assign q_ext    = {1'b0, div_quo};
  assign r_ext    = {{(RW-CW){1'b0}}, div_rem};
  assign last_sample = (CW'(idx) + CW'(1)) == cnt_r;

  // Shared divider
  itv_div #(.DVS_W(CW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (cnt_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // Next state and sequencer controls
  always_comb begin
    state_next = state;
    take       = 1'b0;
    wr_start   = 1'b0;
    wr_init    = 1'b0;
    wr_end     = 1'b0;
    set_known  = 1'b0;
    acc_clr    = 1'b0;
    acc_add    = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    out_load   = 1'b0;
    res_v      = '0;
    res_s      = STAT_OK;
    case (state)
      S_IDLE: begin
        take = 1'b1;
        if (req.valid) state_next = S_FETCH;
      end
      S_FETCH: state_next = S_LOOK;
      S_LOOK: begin
        res_load   = 1'b1;
        state_next = S_RESP;
        if (kind_r == KIND_START) begin
          if (id_ok_r) begin
            wr_start  = 1'b1;
            wr_init   = !known_q[t_r];
            set_known = 1'b1;
          end
        end else if (!(id_ok_r && known_q[t_r])) begin
          res_s = STAT_UNKNOWN;
        end else begin
          case (kind_r)
            KIND_END:  wr_end = 1'b1;
            KIND_LAST: res_v  = last_rd;
            KIND_AVG: begin
              if (cnt_rd == '0) begin
                res_s = STAT_EMPTY;
              end else begin
                res_load   = 1'b0;
                acc_clr    = 1'b1;
                state_next = S_AVG_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_AVG_RD: state_next = S_AVG_GO;
      S_AVG_GO: begin
        div_start  = 1'b1;
        state_next = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (div_done) begin
          acc_add    = 1'b1;
          state_next = last_sample ? S_FIN_GO : S_AVG_RD;
        end
      end
      S_FIN_GO: begin
        div_start  = 1'b1;
        state_next = S_FIN_DIV;
      end
      S_FIN_DIV: begin
        if (div_done) begin
          res_load   = 1'b1;
          res_v      = qacc + (neg_r ? -q_ext : q_ext);
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Transaction capture
  always_ff @(posedge clk) begin
    if (take && req.valid) begin
      kind_r  <= req.kind;
      t_r     <= TW'(req.timer_id);
      id_ok_r <= 32'(req.timer_id) < NUM_TIMERS;
      ts_r    <= req.timestamp;
    end
  end

  // Timer-known flags
  always_ff @(posedge clk) begin
    if (rst)            known_q <= '0;
    else if (set_known) known_q[t_r] <= 1'b1;
  end

  // Per-timer memories
  always_ff @(posedge clk) begin
    if (wr_start) start_mem[t_r] <= ts_r;
    start_rd <= start_mem[t_r];
  end

  always_ff @(posedge clk) begin
    if (wr_init)     last_mem[t_r] <= '0;
    else if (wr_end) last_mem[t_r] <= elapsed;
    last_rd <= last_mem[t_r];
  end

  always_ff @(posedge clk) begin
    if (wr_init)     pos_mem[t_r] <= '0;
    else if (wr_end) pos_mem[t_r] <= wp_next;
    pos_rd <= pos_mem[t_r];
  end

  always_ff @(posedge clk) begin
    if (wr_init)     cnt_mem[t_r] <= '0;
    else if (wr_end) cnt_mem[t_r] <= cnt_next;
    cnt_rd <= cnt_mem[t_r];
  end

  // Sample ring, one row of 2^PW entries per timer
  always_ff @(posedge clk) begin
    if (wr_end) ring_mem[{t_r, wp}] <= elapsed;
    ring_rd <= ring_mem[{t_r, idx}];
  end

  // Average accumulation
  always_ff @(posedge clk) begin
    if (acc_clr) begin
      idx   <= '0;
      qacc  <= '0;
      racc  <= '0;
      cnt_r <= cnt_rd;
    end else if (acc_add) begin
      idx  <= idx + 1'b1;
      qacc <= qacc + (neg_r ? -q_ext : q_ext);
      racc <= racc + (neg_r ? -r_ext : r_ext);
    end
    if (state == S_AVG_GO)      neg_r <= ring_rd[VAL_W-1];
    else if (state == S_FIN_GO) neg_r <= racc[RW-1];
  end

  // Result and output register
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_value  <= res_v;
      res_status <= res_s;
    end
    if (out_load) begin
      out_value  <= res_value;
      out_status <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)             out_valid <= 1'b0;
    else if (out_load)   out_valid <= 1'b1;
    else if (rsp.ready)  out_valid <= 1'b0;
  end

  assign req.ready  = take;
  assign rsp.valid  = out_valid;
  assign rsp.value  = out_value;
  assign rsp.status = out_status;

endmodule
`default_nettype wire

>>> tb/itv_result_checker.sv
// ---------------------------------------------------------------------------
// itv_result_checker
// Watches the request and response channels of the interval timer bank,
// predicts every result from its own copy of the timer state and compares
// each response transaction field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module itv_result_checker #(
  parameter int NUM_TIMERS    = 16,
  parameter int HISTORY_DEPTH = 100
) (
  input  logic clk,
  input  logic rst,
  itv_in_if    req,
  itv_out_if   rsp,
  output int   failures,
  output int   pending
);
  import itv_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic [STATUS_W-1:0] status;
  } timer_result_t;

  // Shadow of the timer bank
  logic             timer_known  [NUM_TIMERS];
  logic [TS_W-1:0]  start_stamp  [NUM_TIMERS];
  longint           last_elapsed [NUM_TIMERS];
  longint           sample_ring  [NUM_TIMERS][HISTORY_DEPTH];
  int               ring_pos     [NUM_TIMERS];
  int               sample_count [NUM_TIMERS];

  timer_result_t    awaited_results [$];

  initial failures = 0;
  initial pending  = 0;

  // Windowed mean with per-sample division, truncating toward zero
  function automatic longint windowed_mean(input int t);
    longint n;
    longint quot_sum;
    longint rem_sum;
    n        = longint'(sample_count[t]);
    quot_sum = 0;
    rem_sum  = 0;
    for (int i = 0; i < sample_count[t]; i++) begin
      quot_sum += sample_ring[t][i] / n;
      rem_sum  += sample_ring[t][i] % n;
    end
    return quot_sum + rem_sum / n;
  endfunction

  // Applies one request to the shadow state and returns its result
  function automatic timer_result_t timer_bank_step(input kind_t op,
                                                    input logic [ID_W-1:0] tid,
                                                    input logic [TS_W-1:0] stamp);
    timer_result_t r;
    int            t;
    longint        lapse;
    r.value  = '0;
    r.status = STAT_OK;
    t        = int'(tid);
    if (op == KIND_START) begin
      if (t < NUM_TIMERS) begin
        if (!timer_known[t]) begin
          timer_known[t]  = 1'b1;
          last_elapsed[t] = 0;
          ring_pos[t]     = 0;
          sample_count[t] = 0;
        end
        start_stamp[t] = stamp;
      end
    end else if (t >= NUM_TIMERS || !timer_known[t]) begin
      r.status = STAT_UNKNOWN;
    end else begin
      case (op)
        KIND_END: begin
          lapse = longint'({16'd0, stamp}) - longint'({16'd0, start_stamp[t]});
          last_elapsed[t]             = lapse;
          sample_ring[t][ring_pos[t]] = lapse;
          ring_pos[t] = (ring_pos[t] + 1 >= HISTORY_DEPTH) ? 0 : ring_pos[t] + 1;
          if (sample_count[t] < HISTORY_DEPTH) sample_count[t]++;
        end
        KIND_LAST: r.value = last_elapsed[t][VAL_W-1:0];
        default: begin
          if (sample_count[t] == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            lapse   = windowed_mean(t);
            r.value = lapse[VAL_W-1:0];
          end
        end
      endcase
    end
    return r;
  endfunction

  // Compare responses first, then queue the prediction for a new request
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (rst) begin
      for (int t = 0; t < NUM_TIMERS; t++) begin
        timer_known[t]  = 1'b0;
        last_elapsed[t] = 0;
        ring_pos[t]     = 0;
        sample_count[t] = 0;
      end
      awaited_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result transaction: value %0d status %0d", $time,
                   $signed(rsp.value), rsp.status);
          failures++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (rsp.value !== exp_r.value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                     $signed(exp_r.value), $signed(rsp.value));
            failures++;
          end
          if (rsp.status !== exp_r.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     exp_r.status, rsp.status);
            failures++;
          end
        end
      end
      if (req.valid && req.ready)
        awaited_results.insert(awaited_results.size(),
                               timer_bank_step(kind_t'(req.kind), req.timer_id,
                                               req.timestamp));
    end
    pending <= awaited_results.size();
  end

endmodule

>>> tb/interval_timer_moving_average_tb.sv
// ---------------------------------------------------------------------------
// interval_timer_moving_average_tb
// Drives timer transactions into the interval timer bank under several
// idling patterns, with a long receiver hold-off, and reports the verdict
// from the failure and pending counts of the result checker.
// ---------------------------------------------------------------------------
module interval_timer_moving_average_tb;
  import itv_pkg::*;

  localparam int NUM_TIMERS    = 16;
  localparam int HISTORY_DEPTH = 100;
  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  itv_in_if  req_if ();
  itv_out_if rsp_if ();

  logic rx_ready     = 1'b0;
  logic rx_hold      = 1'b0;
  int   rx_stall_pct = 0;
  int   tx_idle_pct  = 0;
  int   failures;
  int   pending;
  int unsigned cycle_count = 0;

  // Stamp of the last start issued by the wrap test or a random start/end run, per timer
  logic [TS_W-1:0] run_start [NUM_TIMERS] = '{default: '0};

  always #2 clk = ~clk;

  assign rsp_if.ready = rx_ready;

  interval_timer_moving_average #(
    .NUM_TIMERS    (NUM_TIMERS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  itv_result_checker #(
    .NUM_TIMERS    (NUM_TIMERS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) checker_inst (
    .clk      (clk),
    .rst      (rst),
    .req      (req_if),
    .rsp      (rsp_if),
    .failures (failures),
    .pending  (pending)
  );

  // Response side: random stalls, or held off entirely
  always @(posedge clk) begin
    if (rx_hold) rx_ready <= 1'b0;
    else         rx_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [TS_W-1:0] rand_stamp();
    return TS_W'({$urandom(), $urandom()});
  endfunction

  // Interval between start and end: mostly short, sometimes wide or negative
  function automatic logic [TS_W-1:0] lap_delta();
    case ($urandom_range(0, 9))
      6, 7:    return TS_W'($urandom());
      8:       return TS_W'(0) - TS_W'($urandom_range(1, 50000));
      9:       return rand_stamp();
      default: return TS_W'($urandom_range(0, 50000));
    endcase
  endfunction

  // One request transaction; junk payload while idle
  task automatic send_item(input kind_t op, input logic [ID_W-1:0] tid,
                           input logic [TS_W-1:0] stamp);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_if.valid     <= 1'b0;
      req_if.kind      <= KIND_W'($urandom_range(0, 3));
      req_if.timer_id  <= ID_W'($urandom_range(0, 15));
      req_if.timestamp <= rand_stamp();
      @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.kind      <= op;
    req_if.timer_id  <= tid;
    req_if.timestamp <= stamp;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // Sender pauses until every predicted result has been taken; the count
  // shows the last accepted transaction only once the checker has registered it
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // Mostly start/end/query runs on a few busy timers, some noise
  task automatic random_traffic(input int count);
    int                sent;
    int                ends;
    logic [ID_W-1:0]   tid;
    logic [TS_W-1:0]   base;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 15) begin
        send_item(kind_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, 15)),
                  rand_stamp());
        sent++;
      end else begin
        tid = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 3))
                                         : ID_W'($urandom_range(0, 15));
        // occasionally an end without a fresh start
        if ($urandom_range(0, 4) != 0) begin
          base = rand_stamp();
          run_start[tid] = base;
          send_item(KIND_START, tid, base);
          sent++;
        end
        ends = $urandom_range(1, 6);
        for (int j = 0; j < ends; j++) begin
          send_item(KIND_END, tid, run_start[tid] + lap_delta());
          sent++;
          if ($urandom_range(0, 2) == 0) begin
            send_item(KIND_LAST, tid, rand_stamp());
            sent++;
          end
        end
        if ($urandom_range(0, 99) < 35) begin
          send_item(KIND_AVG, tid, rand_stamp());
          sent++;
        end
      end
    end
  endtask

  initial begin : stimulus
    logic [TS_W-1:0] origin;
    req_if.valid     <= 1'b0;
    req_if.kind      <= KIND_START;
    req_if.timer_id  <= '0;
    req_if.timestamp <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unknown timers, empty history, extreme stamps, negative laps
    send_item(KIND_END,   4'd5,  48'd1234);
    send_item(KIND_LAST,  4'd5,  TS_MAX);
    send_item(KIND_AVG,   4'd15, 48'd0);
    send_item(KIND_START, 4'd0,  48'd0);
    send_item(KIND_AVG,   4'd0,  48'd0);
    send_item(KIND_LAST,  4'd0,  48'd0);
    send_item(KIND_END,   4'd0,  TS_MAX);
    send_item(KIND_LAST,  4'd0,  48'd0);
    send_item(KIND_START, 4'd15, TS_MAX);
    send_item(KIND_END,   4'd15, 48'd0);
    send_item(KIND_LAST,  4'd15, 48'd0);
    send_item(KIND_END,   4'd15, TS_MAX - 48'd7);
    send_item(KIND_AVG,   4'd15, 48'd0);
    send_item(KIND_START, 4'd0,  48'd100);
    send_item(KIND_END,   4'd0,  48'd103);
    send_item(KIND_END,   4'd0,  48'd90);
    send_item(KIND_AVG,   4'd0,  48'd0);
    send_item(KIND_LAST,  4'd0,  48'd0);
    send_item(KIND_START, 4'd15, 48'd5);
    send_item(KIND_AVG,   4'd15, 48'd0);

    // Ring wrap-round: more ends than the history holds
    origin = rand_stamp();
    run_start[2] = origin;
    send_item(KIND_START, 4'd2, origin);
    for (int n = 0; n < HISTORY_DEPTH + 8; n++)
      send_item(KIND_END, 4'd2, origin + lap_delta());
    send_item(KIND_AVG,  4'd2, '0);
    send_item(KIND_LAST, 4'd2, '0);

    // Long receiver hold-off while requests keep coming
    fork
      hold_receiver(300);
      random_traffic(24);
    join
    drain_results();

    // No idling
    random_traffic(170);
    drain_results();

    // Sender idle
    tx_idle_pct = 63;
    random_traffic(170);
    drain_results();

    // Receiver stalling
    tx_idle_pct  = 0;
    rx_stall_pct <= 63;
    random_traffic(170);
    drain_results();

    // Both sides
    tx_idle_pct  = 36;
    rx_stall_pct <= 36;
    random_traffic(170);
    drain_results();

    // Catch any stray late result
    repeat (50) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/itv_pkg.sv
sv/itv_in_if.sv
sv/itv_out_if.sv
sv/itv_div.sv
sv/interval_timer_moving_average.sv
tb/itv_result_checker.sv
tb/interval_timer_moving_average_tb.sv
